[hw/rtl/gor_pkg.sv]
// Shared types, widths and codes for the 1D overlap recurrence unit.
package gor_pkg;

  // Fixed item field widths
  localparam int unsigned AM_W   = 3;
  localparam int unsigned VAL_W  = 48;
  localparam int unsigned G_W    = 47;

  // Multiplier operand, half-word and full product widths
  localparam int unsigned OP_W   = 52;
  localparam int unsigned HALF_W = 26;
  localparam int unsigned PROD_W = 104;

  // Cell accumulator: three 48-bit terms added exactly
  localparam int unsigned SUM_W  = 50;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Which product term of the current cell is being formed
  typedef enum logic [1:0] {
    TERM_OFFSET = 2'd0,
    TERM_SECOND = 2'd1,
    TERM_CROSS  = 2'd2
  } term_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      load_item;
    logic      init_wr;
    logic      step_cell;
    logic      rd_en;
    logic      mul_start;
    logic      acc_add;
    logic      write_cell;
    logic      load_out;
    term_sel_t term;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic a_zero;
    logic a_gt1;
    logic b_zero;
    logic b_gt1;
    logic last_cell;
    logic range_err;
    logic mul_done;
  } status_t;

endpackage

[hw/rtl/gor_if.sv]
// Valid/ready channel interfaces for request and result items.
interface gor_in_if;
  logic                              valid;
  logic                              ready;
  logic        [gor_pkg::AM_W-1:0]   la;
  logic        [gor_pkg::AM_W-1:0]   lb;
  logic signed [gor_pkg::VAL_W-1:0]  offset_pa;
  logic signed [gor_pkg::VAL_W-1:0]  offset_pb;
  logic        [gor_pkg::G_W-1:0]    half_inv_exp;

  modport source (output valid, la, lb, offset_pa, offset_pb, half_inv_exp, input ready);
  modport sink   (input valid, la, lb, offset_pa, offset_pb, half_inv_exp, output ready);
endinterface

interface gor_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [gor_pkg::VAL_W-1:0]  overlap;
  logic                              saturated;

  modport source (output valid, overlap, saturated, input ready);
  modport sink   (input valid, overlap, saturated, output ready);
endinterface

[hw/rtl/gor_fxmul.sv]
// Multi-cycle signed fixed-point multiplier with rounding and saturation.
module gor_fxmul #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [gor_pkg::OP_W-1:0]     op_x,
  input  gor_pkg::val_t                       op_y,
  output logic                                done,
  output gor_pkg::val_t                       term,
  output logic                                sat
);

  localparam int unsigned OPW = gor_pkg::OP_W;
  localparam int unsigned HW  = gor_pkg::HALF_W;
  localparam int unsigned PW  = gor_pkg::PROD_W;
  localparam int unsigned VW  = gor_pkg::VAL_W;
  localparam int unsigned RW  = PW - FRAC_BITS;

  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  typedef enum logic [2:0] {
    M_IDLE,
    M_MULT,
    M_FLUSH,
    M_ROUND,
    M_FINAL
  } mstate_t;

  mstate_t          state_r;
  logic [1:0]       cnt_r;
  logic             neg_r;
  logic [OPW-1:0]   xm_r;
  logic [OPW-1:0]   ym_r;
  logic [2*HW-1:0]  pp_r;
  logic [1:0]       pp_sh_r;
  logic             pp_vld_r;
  logic [PW-1:0]    acc_r;
  logic [RW-1:0]    rnd_r;
  logic             done_r;
  gor_pkg::val_t    term_r;
  logic             sat_r;

  logic [OPW-1:0]   x_mag;
  logic [VW-1:0]    y_abs;
  logic [OPW-1:0]   y_mag;
  logic             neg;
  logic [HW-1:0]    x_part;
  logic [HW-1:0]    y_part;
  logic [2*HW-1:0]  pp_nxt;
  logic [1:0]       pp_sh_nxt;
  logic [PW-1:0]    addend;
  logic [RW-1:0]    lim;
  logic [VW-1:0]    mag48;
  logic             sat_nxt;
  gor_pkg::val_t    term_nxt;

  // Split operands into sign and magnitude
  assign x_mag = op_x[OPW-1] ? OPW'(-op_x) : OPW'(op_x);
  assign y_abs = op_y[VW-1] ? VW'(-op_y) : VW'(op_y);
  assign y_mag = OPW'(y_abs);
  assign neg   = op_x[OPW-1] ^ op_y[VW-1];

  // One half-word partial product per cycle
  assign x_part    = cnt_r[1] ? xm_r[OPW-1:HW] : xm_r[HW-1:0];
  assign y_part    = cnt_r[0] ? ym_r[OPW-1:HW] : ym_r[HW-1:0];
  assign pp_nxt    = x_part * y_part;
  assign pp_sh_nxt = {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};

  // Align the registered partial product
  always_comb begin
    case (pp_sh_r)
      2'd0:    addend = PW'(pp_r);
      2'd1:    addend = PW'(pp_r) << HW;
      2'd2:    addend = PW'(pp_r) << (2 * HW);
      default: addend = '0;
    endcase
  end

  // Saturate and restore the sign of the rounded magnitude
  assign lim      = neg_r ? (RW'(1) << (VW - 1)) : ((RW'(1) << (VW - 1)) - RW'(1));
  assign sat_nxt  = rnd_r > lim;
  assign mag48    = rnd_r[VW-1:0];
  assign term_nxt = sat_nxt ? (neg_r ? gor_pkg::VAL_MIN : gor_pkg::VAL_MAX)
                            : (neg_r ? gor_pkg::val_t'(VW'(0) - mag48)
                                     : gor_pkg::val_t'(mag48));

  // Sequence the product: four partials, flush, round, finish
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= M_IDLE;
      cnt_r    <= '0;
      pp_vld_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r   <= (state_r == M_FINAL);
      pp_vld_r <= (state_r == M_MULT);
      if (pp_vld_r) begin
        acc_r <= acc_r + addend;
      end
      unique case (state_r)
        M_IDLE: begin
          if (start) begin
            neg_r   <= neg;
            xm_r    <= x_mag;
            ym_r    <= y_mag;
            acc_r   <= '0;
            cnt_r   <= '0;
            state_r <= M_MULT;
          end
        end
        M_MULT: begin
          pp_r     <= pp_nxt;
          pp_sh_r  <= pp_sh_nxt;
          cnt_r    <= cnt_r + 2'd1;
          if (cnt_r == 2'd3) begin
            state_r <= M_FLUSH;
          end
        end
        M_FLUSH: begin
          state_r <= M_ROUND;
        end
        M_ROUND: begin
          rnd_r   <= RW'((acc_r + HALF) >> FRAC_BITS);
          state_r <= M_FINAL;
        end
        M_FINAL: begin
          term_r  <= term_nxt;
          sat_r   <= sat_nxt;
          state_r <= M_IDLE;
        end
        default: begin
          state_r <= M_IDLE;
        end
      endcase
    end
  end

  assign done = done_r;
  assign term = term_r;
  assign sat  = sat_r;

endmodule

[hw/rtl/gor_datapath.sv]
// Datapath: item registers, table memory, cell accumulator and output register.
module gor_datapath #(
  parameter int unsigned MAX_AM    = 4,
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  gor_pkg::cmd_t                      cmd,
  output gor_pkg::status_t                   status,
  input  logic        [gor_pkg::AM_W-1:0]    la,
  input  logic        [gor_pkg::AM_W-1:0]    lb,
  input  logic signed [gor_pkg::VAL_W-1:0]   offset_pa,
  input  logic signed [gor_pkg::VAL_W-1:0]   offset_pb,
  input  logic        [gor_pkg::G_W-1:0]     half_inv_exp,
  output gor_pkg::val_t                      out_overlap,
  output logic                               out_saturated
);

  localparam int unsigned IW     = $clog2(MAX_AM + 1);
  localparam int unsigned ADDR_W = 2 * IW;
  localparam int unsigned DEPTH  = 1 << ADDR_W;
  localparam int unsigned OPW    = gor_pkg::OP_W;
  localparam int unsigned VW     = gor_pkg::VAL_W;
  localparam int unsigned SW     = gor_pkg::SUM_W;
  localparam int unsigned GW     = gor_pkg::G_W;

  localparam gor_pkg::val_t ONE = gor_pkg::val_t'(64'(1) << FRAC_BITS);

  // k * g by shift and add over the bits of k
  function automatic logic [OPW-1:0] scale_g(input logic [GW-1:0] g, input logic [IW-1:0] k);
    logic [OPW-1:0] s;
    s = '0;
    for (int i = 0; i < IW; i++) begin
      if (k[i]) begin
        s = s + (OPW'(g) << i);
      end
    end
    return s;
  endfunction

  logic [IW-1:0]           la_r;
  logic [IW-1:0]           lb_r;
  gor_pkg::val_t           pa_r;
  gor_pkg::val_t           pb_r;
  logic [GW-1:0]           g_r;
  logic [IW-1:0]           a_r;
  logic [IW-1:0]           b_r;
  logic                    range_err_r;
  logic signed [SW-1:0]    acc_r;
  gor_pkg::val_t           cell_r;
  logic                    sat_r;
  gor_pkg::val_t           rdata_r;
  gor_pkg::val_t           out_overlap_r;
  logic                    out_sat_r;
  gor_pkg::val_t           mem [DEPTH];

  logic                    range_err_in;
  logic                    a_zero;
  logic [IW-1:0]           ra;
  logic [IW-1:0]           rb;
  logic [ADDR_W-1:0]       rd_addr;
  logic [ADDR_W-1:0]       wr_addr;
  logic [IW-1:0]           k;
  logic signed [OPW-1:0]   coef;
  logic                    mul_done;
  gor_pkg::val_t           mul_term;
  logic                    mul_sat;
  logic                    in_range;
  gor_pkg::val_t           cell_val;

  assign range_err_in = (32'(la) > MAX_AM) || (32'(lb) > MAX_AM);
  assign a_zero       = (a_r == '0);

  // Table address of the operand for the selected term
  always_comb begin
    case (cmd.term)
      gor_pkg::TERM_OFFSET: begin
        ra = a_zero ? a_r : a_r - IW'(1);
        rb = a_zero ? b_r - IW'(1) : b_r;
      end
      gor_pkg::TERM_SECOND: begin
        ra = a_zero ? a_r : a_r - IW'(2);
        rb = a_zero ? b_r - IW'(2) : b_r;
      end
      gor_pkg::TERM_CROSS: begin
        ra = a_r - IW'(1);
        rb = b_r - IW'(1);
      end
      default: begin
        ra = a_r;
        rb = b_r;
      end
    endcase
  end

  assign rd_addr = {ra, rb};
  assign wr_addr = {a_r, b_r};

  // Coefficient for the selected term
  always_comb begin
    case (cmd.term)
      gor_pkg::TERM_SECOND: k = a_zero ? b_r - IW'(1) : a_r - IW'(1);
      gor_pkg::TERM_CROSS:  k = b_r;
      default:              k = '0;
    endcase
  end

  always_comb begin
    case (cmd.term)
      gor_pkg::TERM_OFFSET: begin
        coef = a_zero ? {{(OPW-VW){pb_r[VW-1]}}, pb_r} : {{(OPW-VW){pa_r[VW-1]}}, pa_r};
      end
      default: begin
        coef = $signed(scale_g(g_r, k));
      end
    endcase
  end

  gor_fxmul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_fxmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .op_x  (coef),
    .op_y  (rdata_r),
    .done  (mul_done),
    .term  (mul_term),
    .sat   (mul_sat)
  );

  // Clamp the cell sum to 48 bits
  assign in_range = (acc_r[SW-1:VW-1] == '0) || (acc_r[SW-1:VW-1] == '1);
  assign cell_val = in_range ? gor_pkg::val_t'(acc_r[VW-1:0])
                             : (acc_r[SW-1] ? gor_pkg::VAL_MIN : gor_pkg::VAL_MAX);

  // Item, index, accumulator and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r         <= '0;
      b_r         <= '0;
      range_err_r <= 1'b0;
      sat_r       <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        la_r        <= IW'(la);
        lb_r        <= IW'(lb);
        pa_r        <= offset_pa;
        pb_r        <= offset_pb;
        g_r         <= half_inv_exp;
        a_r         <= '0;
        b_r         <= '0;
        range_err_r <= range_err_in;
        cell_r      <= range_err_in ? '0 : ONE;
        sat_r       <= range_err_in;
      end
      if (cmd.step_cell) begin
        acc_r <= '0;
        if (b_r == lb_r) begin
          b_r <= '0;
          a_r <= a_r + IW'(1);
        end else begin
          b_r <= b_r + IW'(1);
        end
      end
      if (cmd.acc_add) begin
        acc_r <= acc_r + {{(SW-VW){mul_term[VW-1]}}, mul_term};
        sat_r <= sat_r | mul_sat;
      end
      if (cmd.write_cell) begin
        cell_r <= cell_val;
        sat_r  <= sat_r | ~in_range;
      end
      if (cmd.load_out) begin
        out_overlap_r <= cell_r;
        out_sat_r     <= sat_r;
      end
    end
  end

  // Table memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.init_wr) begin
      mem[wr_addr] <= ONE;
    end else if (cmd.write_cell) begin
      mem[wr_addr] <= cell_val;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign status.a_zero    = a_zero;
  assign status.a_gt1     = a_r > IW'(1);
  assign status.b_zero    = (b_r == '0);
  assign status.b_gt1     = b_r > IW'(1);
  assign status.last_cell = (a_r == la_r) && (b_r == lb_r);
  assign status.range_err = range_err_r;
  assign status.mul_done  = mul_done;

  assign out_overlap   = out_overlap_r;
  assign out_saturated = out_sat_r;

endmodule

[hw/rtl/gor_ctrl.sv]
// Controller: walks the table cells and the product terms of each cell.
module gor_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output gor_pkg::cmd_t     cmd,
  input  gor_pkg::status_t  status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_NEXT,
    S_READ,
    S_MUL,
    S_WAIT,
    S_WRITE,
    S_FINISH
  } state_t;

  state_t              state_r;
  gor_pkg::term_sel_t  term_r;
  logic                out_valid_r;

  logic                need_second;
  logic                need_cross;
  logic                out_free;

  assign need_second = status.a_zero ? status.b_gt1 : status.a_gt1;
  assign need_cross  = !status.a_zero && !status.b_zero;
  assign out_free    = !out_valid_r || out_ready;

  // Decode commands from the state
  always_comb begin
    cmd      = '0;
    cmd.term = term_r;
    unique case (state_r)
      S_IDLE:   cmd.load_item  = in_valid;
      S_INIT:   cmd.init_wr    = !status.range_err;
      S_NEXT:   cmd.step_cell  = !status.last_cell;
      S_READ:   cmd.rd_en      = 1'b1;
      S_MUL:    cmd.mul_start  = 1'b1;
      S_WAIT:   cmd.acc_add    = status.mul_done;
      S_WRITE:  cmd.write_cell = 1'b1;
      S_FINISH: cmd.load_out   = out_free;
      default:  cmd.term       = term_r;
    endcase
  end

  // State, term select and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      term_r      <= gor_pkg::TERM_OFFSET;
      out_valid_r <= 1'b0;
    end else begin
      // Raise valid on a finished item, drop it once the item is taken
      if ((state_r == S_FINISH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_INIT;
          end
        end
        S_INIT: begin
          state_r <= status.range_err ? S_FINISH : S_NEXT;
        end
        S_NEXT: begin
          if (status.last_cell) begin
            state_r <= S_FINISH;
          end else begin
            term_r  <= gor_pkg::TERM_OFFSET;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (status.mul_done) begin
            case (term_r)
              gor_pkg::TERM_OFFSET: begin
                if (need_second) begin
                  term_r  <= gor_pkg::TERM_SECOND;
                  state_r <= S_READ;
                end else if (need_cross) begin
                  term_r  <= gor_pkg::TERM_CROSS;
                  state_r <= S_READ;
                end else begin
                  state_r <= S_WRITE;
                end
              end
              gor_pkg::TERM_SECOND: begin
                if (need_cross) begin
                  term_r  <= gor_pkg::TERM_CROSS;
                  state_r <= S_READ;
                end else begin
                  state_r <= S_WRITE;
                end
              end
              default: begin
                state_r <= S_WRITE;
              end
            endcase
          end
        end
        S_WRITE: begin
          state_r <= S_NEXT;
        end
        S_FINISH: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[hw/rtl/gaussian_overlap_1d_recurrence_unit.sv]
// Top level of the 1D Gaussian overlap recurrence unit.
//
//   channel    dir   payload                                         handshake
//   in_chan    in    la, lb, offset_pa, offset_pb, half_inv_exp      valid/ready
//   out_chan   out   overlap, saturated                              valid/ready
//
// Each product term runs on the shared four-pass multiplier, one term at a time.
// One item is in flight at a time; the result register lets the next item enter
// while a result waits. Reset is synchronous, active low, and clears control state.
// A stalled result holds the unit only once the next result is ready to leave.
module gaussian_overlap_1d_recurrence_unit #(
  parameter int unsigned MAX_AM    = 4,
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  gor_in_if.sink     in_chan,
  gor_out_if.source  out_chan
);

  gor_pkg::cmd_t     cmd;
  gor_pkg::status_t  status;
  logic              in_ready;
  logic              out_valid;

  gor_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .status    (status)
  );

  gor_datapath #(
    .MAX_AM    (MAX_AM),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .la            (in_chan.la),
    .lb            (in_chan.lb),
    .offset_pa     (in_chan.offset_pa),
    .offset_pb     (in_chan.offset_pb),
    .half_inv_exp  (in_chan.half_inv_exp),
    .out_overlap   (out_chan.overlap),
    .out_saturated (out_chan.saturated)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

endmodule
